/* design/ctem_pkg.sv */
package ctem_pkg;

  localparam int NUM_SENSORS = 6;
  localparam int POS_W       = 24;
  localparam int MASK_BITS   = 6;
  localparam int STATE_W     = 4;
  localparam int SUM_W       = 32;
  localparam int THR_W       = 24;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(307);

  localparam int IDX_W  = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int DIFF_W = POS_W + 1;
  localparam int SQ_W   = 2 * DIFF_W + 1;
  localparam int ROOT_W = DIFF_W + 1;

  localparam logic [STATE_W-1:0] ROBOT_IDLE    = STATE_W'(0);
  localparam logic [STATE_W-1:0] ROBOT_STATION = STATE_W'(7);
  localparam logic [STATE_W-1:0] ROBOT_ERROR   = STATE_W'(9);

  typedef struct packed {
    logic                    data_ok;
    logic [STATE_W-1:0]      robot_state;
    logic [MASK_BITS-1:0]    cliff_bits;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } in_word_t;

  typedef struct packed {
    logic                 cliff_error;
    logic [MASK_BITS-1:0] error_mask;
  } out_word_t;

  typedef struct packed {
    logic signed [POS_W-1:0] last_x;
    logic signed [POS_W-1:0] last_y;
    logic [SUM_W-1:0]        travel_sum;
  } entry_t;

endpackage

/* design/ctem_state_ram.sv */
module ctem_state_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [ctem_pkg::IDX_W-1:0]  waddr_i,
  input  ctem_pkg::entry_t            wdata_i,
  input  logic [ctem_pkg::IDX_W-1:0]  raddr_i,
  output ctem_pkg::entry_t            rdata_o
);

  ctem_pkg::entry_t mem [ctem_pkg::NUM_SENSORS];
  ctem_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/ctem_isqrt.sv */
module ctem_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ctem_pkg::SQ_W-1:0]    radicand_i,
  output logic                         done_o,
  output logic [ctem_pkg::ROOT_W-1:0]  root_o
);

  localparam int ROOT_W = ctem_pkg::ROOT_W;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;
  localparam int CNT_W  = $clog2(ROOT_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RAD_W-1:0] rad_q;
  logic [REM_W-1:0] rem_q;
  logic [ROOT_W-1:0] root_q;

  logic [REM_W-1:0] shifted;
  logic [REM_W-1:0] trial;
  logic             fits;

  // restoring square root, one result bit per cycle
  always_comb begin
    shifted = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
    trial   = {1'b0, root_q, 2'b01};
    fits    = (shifted >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ROOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= {1'b0, radicand_i};
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[RAD_W-3:0], 2'b00};
      if (fits) begin
        rem_q  <= shifted - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= shifted;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* design/cliff_travel_error_monitor.sv */
// a word with data_ok low is taken and gives no result; an idle robot state
//   arms all sensors and goes straight to the result; otherwise each sensor is
//   scanned: a clear floor is skipped, a cliff runs diff, mul, sum, root and acc
// input stalls from acceptance until the result is in the output register, so a
//   new word waits for the last; the bit-serial square root sets the cost per cliff
// reset: all sensors armed, latches clear, threshold 307; the state ram is not
//   cleared, an armed sensor takes the current position instead of reading it
module cliff_travel_error_monitor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ctem_pkg::in_word_t             in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ctem_pkg::out_word_t            out_word_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ctem_pkg::THR_W-1:0]     cfg_data_i
);

  localparam int NS     = ctem_pkg::NUM_SENSORS;
  localparam int IDX_W  = ctem_pkg::IDX_W;
  localparam int DIFF_W = ctem_pkg::DIFF_W;
  localparam int SQ_W   = ctem_pkg::SQ_W;
  localparam int ROOT_W = ctem_pkg::ROOT_W;
  localparam int SUM_W  = ctem_pkg::SUM_W;
  localparam int POS_W  = ctem_pkg::POS_W;
  localparam int MB     = ctem_pkg::MASK_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_DIFF = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_ROOT = 3'd5;
  localparam logic [2:0] ST_ACC  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0]               state_q, state_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [NS-1:0]            seen_q, seen_d;
  logic [NS-1:0]            armed_q, armed_d;
  logic [NS-1:0]            latched_q, latched_d;
  logic                     err_q, err_d;
  logic [ctem_pkg::THR_W-1:0] thr_q;
  logic                     out_valid_q;
  ctem_pkg::out_word_t      out_word_q;
  ctem_pkg::in_word_t       item_q;

  logic [DIFF_W-1:0]        ax_q, ay_q;
  logic [SUM_W-1:0]         base_q;
  logic [2*DIFF_W-1:0]      sqx_q, sqy_q;

  logic                     in_take;
  logic                     out_free;
  logic                     idle_code;
  logic                     last_sensor;
  logic [NS+MB-1:0]         bits_ext;
  logic [NS+MB-1:0]         lat_ext;

  ctem_pkg::entry_t         rd_entry;
  ctem_pkg::entry_t         wr_entry;
  logic                     ram_we;

  logic signed [POS_W-1:0]  last_x, last_y;
  logic signed [DIFF_W-1:0] dx, dy;
  logic [SQ_W-1:0]          radicand;
  logic                     root_start;
  logic                     root_done;
  logic [ROOT_W-1:0]        root;
  logic [ROOT_W+SUM_W-1:0]  root_ext;
  logic [SUM_W-1:0]         step;
  logic [SUM_W:0]           acc_wide;
  logic [SUM_W-1:0]         new_sum;
  logic                     hit;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign idle_code = (in_word_i.robot_state == ctem_pkg::ROBOT_IDLE)
                  || (in_word_i.robot_state == ctem_pkg::ROBOT_STATION)
                  || (in_word_i.robot_state == ctem_pkg::ROBOT_ERROR);
  assign last_sensor = (idx_q == IDX_W'(NS - 1));
  // sensors beyond the cliff bits see a clear floor
  assign bits_ext = {{NS{1'b0}}, in_word_i.cliff_bits};
  assign lat_ext  = {{MB{1'b0}}, latched_q};

  ctem_state_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (wr_entry),
    .raddr_i (idx_q),
    .rdata_o (rd_entry)
  );

  ctem_isqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (radicand),
    .done_o     (root_done),
    .root_o     (root)
  );

  // armed sensor starts from the current position with an empty sum
  always_comb begin
    last_x = armed_q[idx_q] ? item_q.pos_x : rd_entry.last_x;
    last_y = armed_q[idx_q] ? item_q.pos_y : rd_entry.last_y;
    dx = {item_q.pos_x[POS_W-1], item_q.pos_x} - {last_x[POS_W-1], last_x};
    dy = {item_q.pos_y[POS_W-1], item_q.pos_y} - {last_y[POS_W-1], last_y};
    radicand = {1'b0, sqx_q} + {1'b0, sqy_q};
    root_start = (state_q == ST_SUM);

    root_ext = {{SUM_W{1'b0}}, root};
    step = (|root_ext[ROOT_W+SUM_W-1:SUM_W]) ? '1 : root_ext[SUM_W-1:0];
    acc_wide = {1'b0, base_q} + {1'b0, step};
    new_sum = acc_wide[SUM_W] ? '1 : acc_wide[SUM_W-1:0];
    hit = (new_sum >= {{(SUM_W-ctem_pkg::THR_W){1'b0}}, thr_q});

    ram_we = (state_q == ST_ACC);
    wr_entry.last_x     = item_q.pos_x;
    wr_entry.last_y     = item_q.pos_y;
    wr_entry.travel_sum = new_sum;
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    seen_d    = seen_q;
    armed_d   = armed_q;
    latched_d = latched_q;
    err_d     = err_q;
    case (state_q)
      ST_IDLE: begin
        if (in_take && in_word_i.data_ok) begin
          err_d = 1'b0;
          idx_d = '0;
          if (idle_code) begin
            armed_d = '1;
            state_d = ST_DONE;
          end else begin
            seen_d  = bits_ext[NS-1:0];
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (seen_q[0]) begin
          state_d = ST_DIFF;
        end else begin
          armed_d[idx_q]   = 1'b1;
          latched_d[idx_q] = 1'b0;
          if (last_sensor) begin
            state_d = ST_DONE;
          end else begin
            idx_d  = idx_q + IDX_W'(1);
            seen_d = seen_q >> 1;
          end
        end
      end
      ST_DIFF: state_d = ST_MUL;
      ST_MUL:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_ROOT;
      ST_ROOT: begin
        if (root_done) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        armed_d[idx_q] = 1'b0;
        if (hit) begin
          latched_d[idx_q] = 1'b1;
          err_d            = 1'b1;
        end
        if (last_sensor) begin
          state_d = ST_DONE;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          seen_d  = seen_q >> 1;
          state_d = ST_SCAN;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      seen_q      <= '0;
      armed_q     <= '1;
      latched_q   <= '0;
      err_q       <= 1'b0;
      thr_q       <= ctem_pkg::THR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      seen_q    <= seen_d;
      armed_q   <= armed_d;
      latched_q <= latched_d;
      err_q     <= err_d;
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= cfg_data_i;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= in_word_i;
    end
    if (state_q == ST_DIFF) begin
      ax_q   <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
      ay_q   <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
      base_q <= armed_q[idx_q] ? '0 : rd_entry.travel_sum;
    end
    if (state_q == ST_MUL) begin
      sqx_q <= ax_q * ax_q;
      sqy_q <= ay_q * ay_q;
    end
    if (state_q == ST_DONE && out_free) begin
      out_word_q.cliff_error <= err_q;
      out_word_q.error_mask  <= lat_ext[MB-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_root_only_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_done |-> state_q == ST_ROOT)
    else $error("square root finished outside its wait state");

  a_disarm_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ACC |=> !armed_q[$past(idx_q)])
    else $error("sensor still armed after its travel update");

  a_error_has_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_word_o.cliff_error || out_word_o.error_mask != '0))
    else $error("cliff error reported with an empty mask");

endmodule
